>>> src/atsm_pkg.sv
// ----------------------------------------------------------------------------
// atsm_pkg
// Shared types, sizes and helpers for the ATS eligibility-time meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package atsm_pkg;

  // Time base and group table geometry
  localparam int unsigned TimeW   = 48;
  localparam int unsigned PortW   = 3;
  localparam int unsigned PcpW    = 3;
  localparam int unsigned SlotW   = PortW + PcpW;
  localparam int unsigned Groups  = 1 << SlotW;

  // Field and register widths
  localparam int unsigned LenW    = 14;
  localparam int unsigned TpbW    = 32;
  localparam int unsigned OvhW    = 8;
  localparam int unsigned BurstW  = 20;
  localparam int unsigned MaxResW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  // Q16.16 fraction bits of ticks_per_byte
  localparam int unsigned FracW   = 16;
  localparam int unsigned LsumW   = LenW + 1;
  localparam int unsigned RecPW   = LsumW + TpbW;
  localparam int unsigned RecW    = RecPW - FracW;
  localparam int unsigned EtfPW   = BurstW + TpbW;
  localparam int unsigned EtfW    = EtfPW - FracW;

  // Reset values
  localparam logic [TpbW-1:0]    TpbRst    = TpbW'(65536);
  localparam logic [OvhW-1:0]    OvhRst    = '0;
  localparam logic [BurstW-1:0]  BurstRst  = BurstW'(1522);
  localparam logic [MaxResW-1:0] MaxResRst = '0;

  typedef logic [TimeW-1:0] time_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTicksPerByte = 3'd0,
    CfgOverhead     = 3'd1,
    CfgBurst        = 3'd2,
    CfgResEnable    = 3'd3,
    CfgMaxResidence = 3'd4
  } cfg_idx_e;

  // Saturating time add
  function automatic time_t time_add(input time_t a, input time_t b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

  function automatic time_t time_max(input time_t a, input time_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

>>> src/ats_eligibility_time_meter_core.sv
// ----------------------------------------------------------------------------
// ats_eligibility_time_meter_core
// Pipeline: read into stage 1, multiply into stage 2, update into the result register.
// Throughput: one frame per cycle unless the result channel back-pressures; the
//   bucket-empty register and group table write-back close their loop in the update stage.
// Reset: control and table valid bits clear and config takes its reset values
//   at once; no clearing pass, an entry not yet written reads as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ats_eligibility_time_meter_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // frame descriptor in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [47:0] arrival_time, [61:48] length_bytes, [64:62] port_index,
  // [67:65] priority_code, [71:68] zero
  input  wire logic [71:0] s_axis_tdata,
  // result out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [47:0] eligibility_time
  output logic [47:0]      m_axis_tdata,
  // [0] accepted
  output logic [0:0]       m_axis_tuser
);

  // --------------------------------------------------------------------------
  // Configuration registers. Always ready; to be written only while idle, which the block does not enforce.
  // --------------------------------------------------------------------------
  logic [atsm_pkg::TpbW-1:0]    tpb_q;
  logic [atsm_pkg::OvhW-1:0]    ovh_q;
  logic [atsm_pkg::BurstW-1:0]  burst_q;
  logic                         res_en_q;
  logic [atsm_pkg::MaxResW-1:0] max_res_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpb_q     <= atsm_pkg::TpbRst;
      ovh_q     <= atsm_pkg::OvhRst;
      burst_q   <= atsm_pkg::BurstRst;
      res_en_q  <= 1'b0;
      max_res_q <= atsm_pkg::MaxResRst;
    end else if (cfg_valid_i) begin
      unique case (atsm_pkg::cfg_idx_e'(cfg_index_i))
        atsm_pkg::CfgTicksPerByte: tpb_q     <= cfg_data_i[atsm_pkg::TpbW-1:0];
        atsm_pkg::CfgOverhead:     ovh_q     <= cfg_data_i[atsm_pkg::OvhW-1:0];
        atsm_pkg::CfgBurst:        burst_q   <= cfg_data_i[atsm_pkg::BurstW-1:0];
        atsm_pkg::CfgResEnable:    res_en_q  <= cfg_data_i[0];
        atsm_pkg::CfgMaxResidence: max_res_q <= cfg_data_i[atsm_pkg::MaxResW-1:0];
        default: ;
      endcase
    end
  end

  // Empty-to-full duration depends on config only; refreshed every cycle so
  // it has settled well before the first frame reaches the update stage.
  logic [atsm_pkg::EtfPW-1:0] etf_prod;
  logic [atsm_pkg::EtfW-1:0]  etf_q;

  assign etf_prod = atsm_pkg::EtfPW'(burst_q) * atsm_pkg::EtfPW'(tpb_q);

  always_ff @(posedge clk_i) begin
    etf_q <= etf_prod[atsm_pkg::EtfPW-1:atsm_pkg::FracW];
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake. s1: table read, s2: update, out: result register.
  // --------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, out_vld_q;
  logic out_adv, s2_adv, s1_adv, in_acc;

  assign out_adv       = !out_vld_q || m_axis_tready;
  assign s2_adv        = out_adv;
  assign s1_adv        = !s2_vld_q || s2_adv;
  assign s_axis_tready = !s1_vld_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Input unpacking
  atsm_pkg::time_t              in_arr;
  logic [atsm_pkg::LenW-1:0]    in_len;
  logic [atsm_pkg::SlotW-1:0]   in_slot;

  assign in_arr  = s_axis_tdata[47:0];
  assign in_len  = s_axis_tdata[61:48];
  // port-major index: port * PCP levels + pcp
  assign in_slot = {s_axis_tdata[64:62], s_axis_tdata[67:65]};

  // --------------------------------------------------------------------------
  // Group eligibility table: sync read on accept, write on commit.
  // --------------------------------------------------------------------------
  atsm_pkg::time_t              grp_mem [atsm_pkg::Groups];
  logic [atsm_pkg::Groups-1:0]  grp_vld_q;
  atsm_pkg::time_t              rd_q;
  logic                         rd_vld_q;

  logic                         commit;
  logic [atsm_pkg::SlotW-1:0]   s2_slot_q;
  atsm_pkg::time_t              elig;

  always_ff @(posedge clk_i) begin
    if (commit) begin
      grp_mem[s2_slot_q] <= elig;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= grp_mem[in_slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (commit) begin
        grp_vld_q[s2_slot_q] <= 1'b1;
      end
      if (in_acc) begin
        rd_vld_q <= grp_vld_q[in_slot];
      end
    end
  end

  // Last write record, for a write landing on the read edge
  logic                       wr_vld_q;
  logic [atsm_pkg::SlotW-1:0] wr_slot_q;
  atsm_pkg::time_t            wr_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_vld_q <= 1'b0;
    end else if (commit) begin
      wr_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      wr_slot_q <= s2_slot_q;
      wr_data_q <= elig;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: recovery multiply, residence bound, group forwarding
  // --------------------------------------------------------------------------
  atsm_pkg::time_t             s1_arr_q;
  logic [atsm_pkg::LenW-1:0]   s1_len_q;
  logic [atsm_pkg::SlotW-1:0]  s1_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_arr_q  <= in_arr;
      s1_len_q  <= in_len;
      s1_slot_q <= in_slot;
    end
  end

  logic [atsm_pkg::LsumW-1:0] len_sum;
  logic [atsm_pkg::RecPW-1:0] rec_prod;
  atsm_pkg::time_t            lim;
  atsm_pkg::time_t            grp_fwd;

  assign len_sum  = atsm_pkg::LsumW'(s1_len_q) + atsm_pkg::LsumW'(ovh_q);
  assign rec_prod = atsm_pkg::RecPW'(len_sum) * atsm_pkg::RecPW'(tpb_q);
  assign lim      = atsm_pkg::time_add(s1_arr_q, atsm_pkg::TimeW'(max_res_q));

  // newest first: write retiring now, then last write, then the table
  always_comb begin
    priority if (commit && (s2_slot_q == s1_slot_q)) begin
      grp_fwd = elig;
    end else if (wr_vld_q && (wr_slot_q == s1_slot_q)) begin
      grp_fwd = wr_data_q;
    end else if (rd_vld_q) begin
      grp_fwd = rd_q;
    end else begin
      grp_fwd = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: eligibility and bucket update
  // --------------------------------------------------------------------------
  atsm_pkg::time_t           s2_arr_q;
  logic [atsm_pkg::RecW-1:0] s2_rec_q;
  atsm_pkg::time_t           s2_lim_q;
  atsm_pkg::time_t           s2_grp_q;
  atsm_pkg::time_t           bet_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s1_adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_vld_q) begin
      s2_arr_q  <= s1_arr_q;
      s2_slot_q <= s1_slot_q;
      s2_rec_q  <= rec_prod[atsm_pkg::RecPW-1:atsm_pkg::FracW];
      s2_lim_q  <= lim;
      s2_grp_q  <= grp_fwd;
    end
  end

  atsm_pkg::time_t sched, full, bet_d;
  logic            ok;

  assign sched  = atsm_pkg::time_add(bet_q, atsm_pkg::TimeW'(s2_rec_q));
  assign full   = atsm_pkg::time_add(bet_q, atsm_pkg::TimeW'(etf_q));
  assign elig   = atsm_pkg::time_max(atsm_pkg::time_max(s2_arr_q, s2_grp_q), sched);
  assign ok     = !res_en_q || (elig <= s2_lim_q);
  assign commit = s2_vld_q && s2_adv && ok;

  // full-bucket rule: excess beyond full carries into the empty time
  assign bet_d  = (elig < full) ? sched : atsm_pkg::time_add(sched, elig - full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bet_q <= '0;
    end else if (commit) begin
      bet_q <= bet_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  atsm_pkg::time_t out_elig_q;
  logic            out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s2_vld_q) begin
      out_elig_q <= elig;
      out_ok_q   <= ok;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_elig_q;
  assign m_axis_tuser[0] = out_ok_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // an empty result register never back-pressures the input
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // bucket-empty time only moves forward
  a_bet_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bet_q >= $past(bet_q))
    else $error("bucket-empty time went backwards");

  // a committed group entry is marked valid afterwards
  a_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> grp_vld_q[$past(s2_slot_q)])
    else $error("group entry not marked valid after write");

  // with the limit off no frame is discarded
  a_no_discard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && !res_en_q) |-> ok)
    else $error("frame discarded with residence limit disabled");

  // eligibility never precedes arrival
  a_elig_after_arrival: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> (elig >= s2_arr_q))
    else $error("eligibility time before arrival");
`endif

endmodule

`default_nettype wire
